// ----- src/rrtia_pkg.sv -----
// Shared types and codes for the round-robin identifier allocator.
// No dependencies; used by rrtia_id_split and the allocator top level.
package rrtia_pkg;

  localparam int ID_W   = 16;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_IN_USE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVQ,
    S_RREAD,
    S_RCHECK,
    S_SCAN,
    S_PUSH
  } state_t;

endpackage

// ----- src/rrtia_map_ram.sv -----
// In-use bitmap storage: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the allocator top level.
module rrtia_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rrtia_id_split.sv -----
// Splits an identifier into bitmap word and bit position by reciprocal multiply.
// Two register stages: word index, then remainder. Uses rrtia_pkg.
module rrtia_id_split #(
  parameter int WORD_BITS = 64,
  parameter int AW        = 10,
  parameter int RW        = 6
) (
  input  logic                      clk,
  input  logic [rrtia_pkg::ID_W-1:0] id,
  output logic [AW-1:0]             word,
  output logic [RW-1:0]             bitpos
);

  localparam int L  = $clog2(WORD_BITS);
  localparam int S  = rrtia_pkg::ID_W + L;
  localparam int MW = S + 1;
  localparam int M  = ((1 << S) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW = rrtia_pkg::ID_W + MW;

  logic [PW-1:0]                prod;
  logic [rrtia_pkg::ID_W-1:0]   rem;
  logic [AW-1:0]                word_r;
  logic [RW-1:0]                bitpos_r;

  assign prod = PW'(id) * PW'(M);
  assign rem  = id - rrtia_pkg::ID_W'(rrtia_pkg::ID_W'(word_r) *
                                      rrtia_pkg::ID_W'(WORD_BITS));

  always_ff @(posedge clk) begin
    word_r   <= AW'(prod >> S);
    bitpos_r <= RW'(rem);
  end

  assign word   = word_r;
  assign bitpos = bitpos_r;

endmodule

// ----- src/round_robin_tree_id_allocator_core.sv -----
// Round-robin identifier allocator, top level: control, bitmap scan, result register.
// Allocate: bitmap scan, 1 word/cycle, 1 to LAST_WORD + 2 words read.
// Release, look up: the result waits on the index split and the bitmap read.
// Pool full is known from the in-use count. One item at a time.
// After reset a clearing pass writes every bitmap word, input held off.
// Depends on rrtia_pkg, rrtia_map_ram and rrtia_id_split.
module round_robin_tree_id_allocator_core #(
  parameter int ID_LIMIT      = 65535,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rrtia_pkg::TDATA_W-1:0] in_tdata,   // command[1:0], id_in[17:2]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rrtia_pkg::TDATA_W-1:0] out_tdata   // status[1:0], id_out[17:2]
);

  localparam int IDW       = rrtia_pkg::ID_W;
  localparam int W         = MAP_WORD_BITS;
  localparam int MAP_WORDS = (65536 + W - 1) / W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int RW        = (W > 1) ? $clog2(W) : 1;
  localparam int LAST_ID   = ID_LIMIT - 1;
  localparam int LAST_WORD = LAST_ID / W;
  localparam int LAST_BIT  = LAST_ID % W;
  localparam int P0_WORD   = 1 / W;
  localparam int P0_BIT    = 1 % W;
  localparam int P0_BASE   = P0_WORD * W;

  rrtia_pkg::state_t state_r, state_nxt;

  logic [rrtia_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IDW-1:0]               id_r, id_nxt;
  logic [IDW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [AW-1:0]                pw_r, pw_nxt;
  logic [RW-1:0]                pb_r, pb_nxt;
  logic [IDW-1:0]               pbase_r, pbase_nxt;
  logic [AW-1:0]                sw_r, sw_nxt;
  logic [RW-1:0]                sb_r, sb_nxt;
  logic [IDW-1:0]               sbase_r, sbase_nxt;
  logic [rrtia_pkg::STAT_W-1:0] res_st_r, res_st_nxt;
  logic [IDW-1:0]               res_id_r, res_id_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rrtia_pkg::TDATA_W-1:0] out_data_r, out_data_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [W-1:0]   mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [W-1:0]   mem_rdata;
  logic [AW-1:0]  split_word;
  logic [RW-1:0]  split_bit;

  logic           in_acc;
  logic           pool_full;
  logic           in_pool;
  logic           used;
  logic [W-1:0]   scan_mask;
  logic [W-1:0]   free_bits;
  logic           found;
  logic [RW-1:0]  idx;
  logic [IDW-1:0] alloc_id;
  logic           push_ok;

  rrtia_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (W),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrtia_id_split #(
    .WORD_BITS (W),
    .AW        (AW),
    .RW        (RW)
  ) u_split (
    .clk    (clk),
    .id     (id_r),
    .word   (split_word),
    .bitpos (split_bit)
  );

  assign in_tready  = (state_r == rrtia_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign pool_full  = (cnt_r == IDW'(LAST_ID));
  assign in_pool    = (id_r != '0) && (id_r < IDW'(ID_LIMIT));
  assign used       = in_pool && mem_rdata[split_bit];
  assign push_ok    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int b = 0; b < W; b++) begin
      scan_mask[b] = (RW'(b) >= sb_r) &&
                     !((sw_r == '0) && (b == 0)) &&
                     !((sw_r == AW'(LAST_WORD)) && (RW'(b) > RW'(LAST_BIT)));
    end
  end

  assign free_bits = ~mem_rdata & scan_mask;
  assign found     = |free_bits;

  always_comb begin
    idx = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        idx = RW'(b);
      end
    end
  end

  assign alloc_id = sbase_r + IDW'(idx);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrtia_pkg::S_CLEAR: begin
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = rrtia_pkg::S_IDLE;
        end
      end
      rrtia_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tdata[1:0] != rrtia_pkg::CMD_ALLOC) begin
            state_nxt = rrtia_pkg::S_DIVQ;
          end else if (pool_full) begin
            state_nxt = rrtia_pkg::S_PUSH;
          end else begin
            state_nxt = rrtia_pkg::S_SCAN;
          end
        end
      end
      rrtia_pkg::S_DIVQ:   state_nxt = rrtia_pkg::S_RREAD;
      rrtia_pkg::S_RREAD:  state_nxt = rrtia_pkg::S_RCHECK;
      rrtia_pkg::S_RCHECK: state_nxt = rrtia_pkg::S_PUSH;
      rrtia_pkg::S_SCAN: begin
        if (found) begin
          state_nxt = rrtia_pkg::S_PUSH;
        end
      end
      rrtia_pkg::S_PUSH: begin
        if (push_ok) begin
          state_nxt = rrtia_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrtia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    pw_nxt        = pw_r;
    pb_nxt        = pb_r;
    pbase_nxt     = pbase_r;
    sw_nxt        = sw_r;
    sb_nxt        = sb_r;
    sbase_nxt     = sbase_r;
    res_st_nxt    = res_st_r;
    res_id_nxt    = res_id_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = sw_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = split_word;
    unique case (state_r)
      rrtia_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      rrtia_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_tdata[1:0];
          id_nxt     = in_tdata[17:2];
          res_st_nxt = rrtia_pkg::ST_FULL;
          res_id_nxt = '0;
          mem_raddr  = pw_r;
          sw_nxt     = pw_r;
          sb_nxt     = pb_r;
          sbase_nxt  = pbase_r;
        end
      end
      rrtia_pkg::S_DIVQ: begin
      end
      rrtia_pkg::S_RREAD: begin
        mem_raddr = split_word;
      end
      rrtia_pkg::S_RCHECK: begin
        res_id_nxt = id_r;
        res_st_nxt = rrtia_pkg::ST_NOT_IN_USE;
        case (cmd_r)
          rrtia_pkg::CMD_RELEASE: begin
            if (used) begin
              mem_we     = 1'b1;
              mem_waddr  = split_word;
              mem_wdata  = mem_rdata & ~(W'(1) << split_bit);
              cnt_nxt    = cnt_r - IDW'(1);
              res_st_nxt = rrtia_pkg::ST_OK;
            end
          end
          rrtia_pkg::CMD_LOOKUP: begin
            if (used) begin
              res_st_nxt = rrtia_pkg::ST_OK;
            end
          end
          default: begin
          end
        endcase
      end
      rrtia_pkg::S_SCAN: begin
        if (found) begin
          mem_we     = 1'b1;
          mem_waddr  = sw_r;
          mem_wdata  = mem_rdata | (W'(1) << idx);
          cnt_nxt    = cnt_r + IDW'(1);
          res_st_nxt = rrtia_pkg::ST_OK;
          res_id_nxt = alloc_id;
          if (alloc_id == IDW'(LAST_ID)) begin
            pw_nxt    = AW'(P0_WORD);
            pb_nxt    = RW'(P0_BIT);
            pbase_nxt = IDW'(P0_BASE);
          end else if (idx == RW'(W - 1)) begin
            pw_nxt    = sw_r + AW'(1);
            pb_nxt    = '0;
            pbase_nxt = sbase_r + IDW'(W);
          end else begin
            pw_nxt    = sw_r;
            pb_nxt    = idx + RW'(1);
            pbase_nxt = sbase_r;
          end
        end else begin
          sb_nxt = '0;
          if (sw_r == AW'(LAST_WORD)) begin
            sw_nxt    = '0;
            sbase_nxt = '0;
          end else begin
            sw_nxt    = sw_r + AW'(1);
            sbase_nxt = sbase_r + IDW'(W);
          end
          mem_raddr = sw_nxt;
        end
      end
      rrtia_pkg::S_PUSH: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_id_r, res_st_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrtia_pkg::S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pw_r        <= AW'(P0_WORD);
      pb_r        <= RW'(P0_BIT);
      pbase_r     <= IDW'(P0_BASE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pw_r        <= pw_nxt;
      pb_r        <= pb_nxt;
      pbase_r     <= pbase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    sw_r       <= sw_nxt;
    sb_r       <= sb_nxt;
    sbase_r    <= sbase_nxt;
    res_st_r   <= res_st_nxt;
    res_id_r   <= res_id_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
